// ===== hdl/prfp_pkg.sv =====
// ============================================================================
// Pixel ray floor projection package
// Shared widths, register indexes, calibration states and pipeline structs.
// ============================================================================
`default_nettype none

package prfp_pkg;

  localparam int NUM_W        = 104;
  localparam int DEN_W        = 59;
  localparam int DIV_BITS     = 41;
  localparam int DEN_SHIFT    = 15;
  localparam int CMP_W        = DEN_W + DEN_SHIFT + DIV_BITS - 1;
  localparam int RAY_W        = 43;
  localparam int K_W          = 62;
  localparam int K_HALF       = 31;
  localparam int OUT_W        = 32;
  localparam int FRONT_STAGES = 7;
  localparam int BACK_STAGES  = 2;
  localparam int LATENCY      = FRONT_STAGES + DIV_BITS + BACK_STAGES;

  localparam logic [DIV_BITS-1:0] MAG_CAP = DIV_BITS'(1) << (DIV_BITS - 1);

  localparam logic [2:0] REG_CAMERA_Z      = 3'd0;
  localparam logic [2:0] REG_NEAR_DISTANCE = 3'd1;
  localparam logic [2:0] REG_TAN_HALF_FOV  = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_FLOOR_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_GRAVITY       = 3'd6;

  typedef enum logic [1:0] {
    CAL_SUM,
    CAL_ROOT,
    CAL_MUL,
    CAL_IDLE
  } cal_state_t;

  typedef struct packed {
    logic [30:0] near_distance;
    logic [23:0] tan_half_fov;
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [31:0] floor_height;
    logic [47:0] gravity;
  } cfg_t;

  typedef struct packed {
    logic       par;
    logic [2:0] neg;
    logic [2:0] zero;
  } side_t;

  typedef struct packed {
    logic                     vld;
    side_t                    side;
    logic [2:0]               ovf;
    logic [DEN_W-1:0]         d;
    logic [2:0][NUM_W-1:0]    n;
  } div_in_t;

  typedef struct packed {
    logic                     vld;
    side_t                    side;
    logic [2:0]               ovf;
    logic [2:0][DIV_BITS-1:0] q;
  } div_out_t;

endpackage

`default_nettype wire

// ===== hdl/prfp_calib.sv =====
// ============================================================================
// Scale factor calibration
// Computes floor height magnitude times the gravity norm (root of the sum of squares).
// ============================================================================
`default_nettype none

module prfp_calib (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 restart,
  input  logic [47:0]          gravity,
  input  logic [31:0]          floor_height,
  output logic [prfp_pkg::K_W-1:0] k,
  output logic                 busy
);
  import prfp_pkg::*;

  localparam logic [61:0] BIT_START = 62'(1) << 60;

  cal_state_t state_r, state_nxt;
  logic [61:0] v_r, v_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic signed [15:0] gx, gy, gz;
  logic signed [31:0] sx, sy, sz;
  logic [31:0] sumsq, hmag;
  logic [62:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CAL_SUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    k_r   <= k_nxt;
  end

  always_comb begin
    gx    = $signed(gravity[15:0]);
    gy    = $signed(gravity[31:16]);
    gz    = $signed(gravity[47:32]);
    sx    = gx * gx;
    sy    = gy * gy;
    sz    = gz * gz;
    sumsq = 32'(sx) + 32'(sy) + 32'(sz);
    hmag  = floor_height[31] ? 32'(-floor_height) : floor_height;
    trial = 63'(r_r) + 63'(bit_r);
    state_nxt = state_r;
    v_nxt   = v_r;
    r_nxt   = r_r;
    bit_nxt = bit_r;
    k_nxt   = k_r;
    unique case (state_r)
      CAL_SUM: begin
        v_nxt     = {sumsq, 30'b0};
        r_nxt     = '0;
        bit_nxt   = BIT_START;
        state_nxt = CAL_ROOT;
      end
      CAL_ROOT: begin
        if (63'(v_r) >= trial) begin
          v_nxt = v_r - trial[61:0];
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = CAL_MUL;
        end
      end
      CAL_MUL: begin
        k_nxt     = K_W'(hmag) * K_W'(r_r[30:0]);
        state_nxt = CAL_IDLE;
      end
      default: begin
        state_nxt = CAL_IDLE;
      end
    endcase
    if (restart) begin
      state_nxt = CAL_SUM;
    end
  end

  assign k    = k_r;
  assign busy = (state_r != CAL_IDLE);

endmodule

`default_nettype wire

// ===== hdl/prfp_front.sv =====
// ============================================================================
// Ray setup pipeline
// Builds the ray, its dot product with gravity and the wide numerators.
// ============================================================================
`default_nettype none

module prfp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_in,
  input  logic [15:0]               px,
  input  logic [15:0]               py,
  input  prfp_pkg::cfg_t            cfg,
  input  logic [prfp_pkg::K_W-1:0]  k,
  output prfp_pkg::div_in_t         dout
);
  import prfp_pkg::*;

  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;

  logic signed [18:0] a1_r, b1_r, a1_nxt, b1_nxt;
  logic signed [43:0] mx, my;
  logic signed [RAY_W-1:0] r2_r [3], r2_nxt [3];
  logic signed [RAY_W-1:0] r3_r [3];
  logic signed [58:0] p3_r [3], p3_nxt [3];
  logic signed [59:0] d4_r, d4_nxt;
  logic [41:0] rabs4_r [3], rabs4_nxt [3];
  logic [2:0] rneg4_r, rneg4_nxt, rzero4_r, rzero4_nxt;
  logic [72:0] plo5_r [3], plo5_nxt [3], phi5_r [3], phi5_nxt [3];
  logic [DEN_W-1:0] dabs5_r, dabs5_nxt, dabs6_r, dabs7_r;
  side_t side5_r, side5_nxt, side6_r, side7_r;
  logic [NUM_W-1:0] n6_r [3], n6_nxt [3], n7_r [3];
  logic [2:0] ovf7_r, ovf7_nxt;
  logic signed [15:0] g [3];
  logic signed [RAY_W:0] rneg_t [3];
  logic signed [59:0] dneg_t;
  logic dpos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  always_comb begin
    a1_nxt = $signed({2'b00, px, 1'b0}) - $signed({3'b000, cfg.image_width, 4'b0000});
    b1_nxt = $signed({3'b000, cfg.image_height, 4'b0000}) - $signed({2'b00, py, 1'b0});
    mx = a1_r * $signed({1'b0, cfg.tan_half_fov});
    my = b1_r * $signed({1'b0, cfg.tan_half_fov});
    r2_nxt[0] = mx[RAY_W-1:0];
    r2_nxt[1] = my[RAY_W-1:0];
    r2_nxt[2] = -$signed({11'b0, cfg.image_height, 20'b0});
    g[0] = $signed(cfg.gravity[15:0]);
    g[1] = $signed(cfg.gravity[31:16]);
    g[2] = $signed(cfg.gravity[47:32]);
    for (int c = 0; c < 3; c++) begin
      p3_nxt[c] = g[c] * r2_r[c];
    end
    d4_nxt = {p3_r[0][58], p3_r[0]} + {p3_r[1][58], p3_r[1]} + {p3_r[2][58], p3_r[2]};
    for (int c = 0; c < 3; c++) begin
      rneg_t[c]     = -{r3_r[c][RAY_W-1], r3_r[c]};
      rneg4_nxt[c]  = r3_r[c][RAY_W-1];
      rzero4_nxt[c] = (r3_r[c] == '0);
      rabs4_nxt[c]  = r3_r[c][RAY_W-1] ? rneg_t[c][41:0] : r3_r[c][41:0];
    end
    dneg_t    = -d4_r;
    dabs5_nxt = d4_r[59] ? dneg_t[DEN_W-1:0] : d4_r[DEN_W-1:0];
    dpos      = !d4_r[59] && (d4_r != '0);
    side5_nxt.par = (d4_r == '0) || (cfg.near_distance == '0);
    for (int c = 0; c < 3; c++) begin
      side5_nxt.neg[c]  = rneg4_r[c] ^ cfg.floor_height[31] ^ (!side5_nxt.par && dpos);
      side5_nxt.zero[c] = rzero4_r[c] || (cfg.floor_height == '0);
      plo5_nxt[c] = 73'(rabs4_r[c]) * 73'(k[K_HALF-1:0]);
      phi5_nxt[c] = 73'(rabs4_r[c]) * 73'(k[K_W-1:K_HALF]);
      n6_nxt[c]   = NUM_W'(plo5_r[c]) + (NUM_W'(phi5_r[c]) << K_HALF);
      ovf7_nxt[c] = DEN_W'(n6_r[c][NUM_W-1:DEN_SHIFT+DIV_BITS]) >= dabs6_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r     <= a1_nxt;
    b1_r     <= b1_nxt;
    r2_r     <= r2_nxt;
    r3_r     <= r2_r;
    p3_r     <= p3_nxt;
    d4_r     <= d4_nxt;
    rabs4_r  <= rabs4_nxt;
    rneg4_r  <= rneg4_nxt;
    rzero4_r <= rzero4_nxt;
    plo5_r   <= plo5_nxt;
    phi5_r   <= phi5_nxt;
    dabs5_r  <= dabs5_nxt;
    side5_r  <= side5_nxt;
    n6_r     <= n6_nxt;
    dabs6_r  <= dabs5_r;
    side6_r  <= side5_r;
    n7_r     <= n6_r;
    dabs7_r  <= dabs6_r;
    side7_r  <= side6_r;
    ovf7_r   <= ovf7_nxt;
  end

  always_comb begin
    dout.vld  = vld7_r;
    dout.side = side7_r;
    dout.ovf  = ovf7_r;
    dout.d    = dabs7_r;
    for (int c = 0; c < 3; c++) begin
      dout.n[c] = n7_r[c];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/prfp_divider.sv =====
// ============================================================================
// Pipelined restoring divider
// Three lanes sharing one divisor, one quotient bit per register stage.
// ============================================================================
`default_nettype none

module prfp_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prfp_pkg::div_in_t    din,
  output prfp_pkg::div_out_t   dout
);
  import prfp_pkg::*;

  logic                      vld_r  [DIV_BITS];
  side_t                     side_r [DIV_BITS];
  logic [2:0]                ovf_r  [DIV_BITS];
  logic [2:0][DIV_BITS-1:0]  q_r    [DIV_BITS];
  logic [2:0][NUM_W-1:0]     rem_r  [DIV_BITS-1];
  logic [DEN_W-1:0]          d_r    [DIV_BITS-1];

  for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
    localparam int QB = DIV_BITS - 1 - s;
    localparam int SH = DEN_SHIFT + QB;

    logic                     vld_i;
    side_t                    side_i;
    logic [2:0]               ovf_i;
    logic [2:0][DIV_BITS-1:0] q_i;
    logic [2:0][NUM_W-1:0]    rem_i;
    logic [DEN_W-1:0]         d_i;
    logic [CMP_W:0]           trial [3];
    logic [2:0]               ge;
    logic [2:0][DIV_BITS-1:0] q_nxt;

    if (s == 0) begin : g_first
      assign vld_i  = din.vld;
      assign side_i = din.side;
      assign ovf_i  = din.ovf;
      assign q_i    = '0;
      assign rem_i  = din.n;
      assign d_i    = din.d;
    end else begin : g_next
      assign vld_i  = vld_r[s-1];
      assign side_i = side_r[s-1];
      assign ovf_i  = ovf_r[s-1];
      assign q_i    = q_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign d_i    = d_r[s-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c]     = {1'b0, CMP_W'(rem_i[c])} - {1'b0, CMP_W'(d_i) << SH};
        ge[c]        = !trial[c][CMP_W];
        q_nxt[c]     = q_i[c];
        q_nxt[c][QB] = ge[c];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      side_r[s] <= side_i;
      ovf_r[s]  <= ovf_i;
      q_r[s]    <= q_nxt;
    end

    if (s < DIV_BITS - 1) begin : g_rem
      logic [2:0][NUM_W-1:0] rem_nxt;
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          rem_nxt[c] = ge[c] ? trial[c][NUM_W-1:0] : rem_i[c];
        end
      end
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        d_r[s]   <= d_i;
      end
    end
  end

  always_comb begin
    dout.vld  = vld_r[DIV_BITS-1];
    dout.side = side_r[DIV_BITS-1];
    dout.ovf  = ovf_r[DIV_BITS-1];
    dout.q    = q_r[DIV_BITS-1];
  end

endmodule

`default_nettype wire

// ===== hdl/prfp_back.sv =====
// ============================================================================
// Result assembly
// Caps magnitudes, applies signs and camera offset, clamps to 32 bits.
// ============================================================================
`default_nettype none

module prfp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prfp_pkg::div_out_t           din,
  input  logic [31:0]                  camera_z,
  output logic                         vld,
  output logic [prfp_pkg::OUT_W-1:0]   floor_x,
  output logic [prfp_pkg::OUT_W-1:0]   floor_y,
  output logic [prfp_pkg::OUT_W-1:0]   floor_z,
  output logic                         parallel
);
  import prfp_pkg::*;

  localparam int W_W = DIV_BITS + 3;

  logic vld1_r, vld2_r, par1_r, par2_r;
  logic [DIV_BITS-1:0] mag [3];
  logic signed [W_W-1:0] w [3];
  logic signed [W_W-1:0] v1_r [3], v1_nxt [3];
  logic [OUT_W-1:0] o2_r [3], o2_nxt [3];

  function automatic logic [OUT_W-1:0] clamp(input logic signed [W_W-1:0] v);
    logic [OUT_W-1:0] res;
    if (v[W_W-1:OUT_W-1] == {(W_W-OUT_W+1){v[W_W-1]}}) begin
      res = v[OUT_W-1:0];
    end else begin
      res = v[W_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (din.side.zero[c]) begin
        mag[c] = '0;
      end else if (din.side.par || din.ovf[c] || (din.q[c] > MAG_CAP)) begin
        mag[c] = MAG_CAP;
      end else begin
        mag[c] = din.q[c];
      end
      w[c] = din.side.neg[c] ? -$signed({3'b000, mag[c]}) : $signed({3'b000, mag[c]});
    end
    v1_nxt[0] = w[0];
    v1_nxt[1] = -w[1];
    v1_nxt[2] = -(w[2] + W_W'($signed(camera_z)));
    for (int c = 0; c < 3; c++) begin
      o2_nxt[c] = clamp(v1_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= din.vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    v1_r   <= v1_nxt;
    par1_r <= din.side.par;
    o2_r   <= o2_nxt;
    par2_r <= par1_r;
  end

  assign vld      = vld2_r;
  assign floor_x  = o2_r[0];
  assign floor_y  = o2_r[1];
  assign floor_z  = o2_r[2];
  assign parallel = par2_r;

endmodule

`default_nettype wire

// ===== hdl/pixel_ray_floor_projection_unit.sv =====
// ============================================================================
// Pixel ray floor projection unit
// Projects image keypoints through a pinhole camera onto the floor plane.
// ============================================================================
// An accepted start passes through the front, divider and back stages to its out_valid strobe.
// One keypoint is accepted every cycle while busy is low; the 41-stage divider dominates the depth.
// After reset and after every register write, busy stays high
// while the gravity norm and scale factor are computed iteratively.
// Reset clears all pipeline valid bits and loads the register defaults.
`default_nettype none

module pixel_ray_floor_projection_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pixel_x,
  input  logic [15:0] in_pixel_y,
  output logic        out_valid,
  output logic signed [31:0] out_floor_x,
  output logic signed [31:0] out_floor_y,
  output logic signed [31:0] out_floor_z,
  output logic        out_ray_parallel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import prfp_pkg::*;

  logic [31:0] camz_r, fh_r;
  logic [30:0] near_r;
  logic [23:0] tan_r;
  logic [11:0] width_r, height_r;
  logic [47:0] grav_r;
  logic        cfg_wr;
  logic [2:0]  idx;
  cfg_t        cfg;
  logic [K_W-1:0] k;
  div_in_t     div_in;
  div_out_t    div_out;
  logic [OUT_W-1:0] fx, fy, fz;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camz_r   <= 32'd0;
      near_r   <= 31'd65536;
      tan_r    <= 24'd27146;
      width_r  <= 12'd640;
      height_r <= 12'd480;
      fh_r     <= 32'd65536;
      grav_r   <= 48'hC000_0000;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_CAMERA_Z:      camz_r   <= pwdata[31:0];
        REG_NEAR_DISTANCE: near_r   <= pwdata[30:0];
        REG_TAN_HALF_FOV:  tan_r    <= pwdata[23:0];
        REG_IMAGE_WIDTH:   width_r  <= pwdata[11:0];
        REG_IMAGE_HEIGHT:  height_r <= pwdata[11:0];
        REG_FLOOR_HEIGHT:  fh_r     <= pwdata[31:0];
        REG_GRAVITY:       grav_r   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAMERA_Z:      prdata = 64'(camz_r);
      REG_NEAR_DISTANCE: prdata = 64'(near_r);
      REG_TAN_HALF_FOV:  prdata = 64'(tan_r);
      REG_IMAGE_WIDTH:   prdata = 64'(width_r);
      REG_IMAGE_HEIGHT:  prdata = 64'(height_r);
      REG_FLOOR_HEIGHT:  prdata = 64'(fh_r);
      REG_GRAVITY:       prdata = 64'(grav_r);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.near_distance = near_r;
    cfg.tan_half_fov  = tan_r;
    cfg.image_width   = width_r;
    cfg.image_height  = height_r;
    cfg.floor_height  = fh_r;
    cfg.gravity       = grav_r;
  end

  prfp_calib u_calib (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (cfg_wr),
    .gravity      (grav_r),
    .floor_height (fh_r),
    .k            (k),
    .busy         (busy)
  );

  prfp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (start && !busy),
    .px     (in_pixel_x),
    .py     (in_pixel_y),
    .cfg    (cfg),
    .k      (k),
    .dout   (div_in)
  );

  prfp_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .din   (div_in),
    .dout  (div_out)
  );

  prfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .din      (div_out),
    .camera_z (camz_r),
    .vld      (out_valid),
    .floor_x  (fx),
    .floor_y  (fy),
    .floor_z  (fz),
    .parallel (out_ray_parallel)
  );

  assign out_floor_x = $signed(fx);
  assign out_floor_y = $signed(fy);
  assign out_floor_z = $signed(fz);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transfer did not produce a result on time");

  a_parallel_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ray_parallel) |->
      (out_floor_x == 32'sh7FFF_FFFF || out_floor_x == -32'sh8000_0000 ||
       out_floor_x == 32'sh0000_0000))
    else $error("parallel ray result is not saturated");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) |=> busy)
    else $error("register write did not restart calibration");

endmodule

`default_nettype wire

// ===== sim/pixel_ray_floor_projection_unit_test.sv =====
// ============================================================================
// Pixel ray floor projection unit testbench
// Streams keypoints through the unit under several camera settings. Every
// accepted keypoint is projected by an independent model in this file, and
// each output strobe is compared field by field with the oldest projection.
// ============================================================================
module pixel_ray_floor_projection_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint BIG_MAG = 64'sd1 << 40;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               par;
  } floor_point_t;

  typedef struct {
    logic [15:0]  px;
    logic [15:0]  py;
    bit           known;
    floor_point_t want;
  } keypoint_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_pixel_x;
  logic [15:0] in_pixel_y;
  logic        out_valid;
  logic signed [31:0] out_floor_x;
  logic signed [31:0] out_floor_y;
  logic signed [31:0] out_floor_z;
  logic        out_ray_parallel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  pixel_ray_floor_projection_unit DUT (.*);

  longint signed   cam_z;
  longint unsigned near_dist;
  longint unsigned tan_fov;
  longint unsigned img_w;
  longint unsigned img_h;
  longint signed   floor_h;
  logic [47:0]     grav;

  floor_point_t pending_points[$];
  int errors;
  int idle_cycles;
  int points_sent;
  int points_checked;
  int parallel_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sgn(longint signed v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(longint signed v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic floor_point_t project_keypoint(logic [15:0] px, logic [15:0] py);
    longint signed   ray[3];
    longint signed   g[3];
    longint signed   w[3];
    longint signed   dot;
    longint unsigned sumsq;
    longint unsigned nrm;
    longint unsigned hmag;
    longint unsigned rabs;
    longint unsigned dabs;
    logic [127:0]    num;
    logic [127:0]    q;
    longint signed   mag;
    bit              par;
    int              s;
    floor_point_t    res;
    ray[0] = (2 * longint'(px) - 16 * longint'(img_w)) * longint'(tan_fov);
    ray[1] = (16 * longint'(img_h) - 2 * longint'(py)) * longint'(tan_fov);
    ray[2] = -16 * longint'(img_h) * 65536;
    dot = 0;
    sumsq = 0;
    for (int c = 0; c < 3; c++) begin
      g[c] = longint'($signed(grav[16*c +: 16]));
      dot = dot + g[c] * ray[c];
      sumsq = sumsq + longint'(g[c] * g[c]);
    end
    nrm = isqrt(sumsq << 30);
    hmag = (floor_h < 0) ? longint'(-floor_h) : longint'(floor_h);
    par = (dot == 0) || (near_dist == 0);
    dabs = (dot < 0) ? longint'(-dot) : longint'(dot);
    for (int c = 0; c < 3; c++) begin
      s = sgn(ray[c]) * sgn(floor_h);
      if (par) begin
        mag = BIG_MAG;
      end else begin
        rabs = (ray[c] < 0) ? longint'(-ray[c]) : longint'(ray[c]);
        s = s * -sgn(dot);
        num = 128'(rabs) * 128'(hmag * nrm);
        q = (num / 128'(dabs)) >> 15;
        mag = (q > 128'(BIG_MAG)) ? BIG_MAG : longint'(q[63:0]);
      end
      w[c] = s * mag;
    end
    w[2] = w[2] + cam_z;
    res.fx = sat32(w[0]);
    res.fy = sat32(-w[1]);
    res.fz = sat32(-w[2]);
    res.par = par;
    return res;
  endfunction

  task automatic write_register(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CAMERA_Z:      cam_z = longint'($signed(value[31:0]));
      REG_NEAR_DISTANCE: near_dist = value[30:0];
      REG_TAN_HALF_FOV:  tan_fov = value[23:0];
      REG_IMAGE_WIDTH:   img_w = value[11:0];
      REG_IMAGE_HEIGHT:  img_h = value[11:0];
      REG_FLOOR_HEIGHT:  floor_h = longint'($signed(value[31:0]));
      default:           grav = value[47:0];
    endcase
  endtask

  task automatic send_keypoint(logic [15:0] px, logic [15:0] py, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 31) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_points.push_back(project_keypoint(px, py));
    points_sent++;
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    floor_point_t exp_pt;
    if (rst_n && out_valid) begin
      points_checked++;
      if (out_ray_parallel) parallel_seen++;
      if (pending_points.size() == 0) begin
        $error("Unexpected output transfer");
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_floor_x !== exp_pt.fx) begin
          $error("floor_x expected %0d actual %0d", exp_pt.fx, out_floor_x);
          errors++;
        end
        if (out_floor_y !== exp_pt.fy) begin
          $error("floor_y expected %0d actual %0d", exp_pt.fy, out_floor_y);
          errors++;
        end
        if (out_floor_z !== exp_pt.fz) begin
          $error("floor_z expected %0d actual %0d", exp_pt.fz, out_floor_z);
          errors++;
        end
        if (out_ray_parallel !== exp_pt.par) begin
          $error("ray_parallel expected %0b actual %0b", exp_pt.par, out_ray_parallel);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  keypoint_row_t directed[$];

  initial begin
    logic [63:0] v[7];
    logic [15:0] px;
    logic [15:0] py;
    floor_point_t got;
    errors = 0;
    points_sent = 0;
    points_checked = 0;
    parallel_seen = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cam_z = 0;
    near_dist = 65536;
    tan_fov = 27146;
    img_w = 640;
    img_h = 480;
    floor_h = 65536;
    grav = 48'hC000_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back('{16'd5120, 16'd3840, 1'b1, '{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 1'b1}});
    directed.push_back('{16'd0, 16'd0, 1'b0, '0});
    directed.push_back('{16'hFFFF, 16'hFFFF, 1'b0, '0});
    directed.push_back('{16'd0, 16'hFFFF, 1'b0, '0});
    directed.push_back('{16'hFFFF, 16'd0, 1'b0, '0});
    directed.push_back('{16'd5120, 16'd0, 1'b0, '0});
    directed.push_back('{16'd0, 16'd3840, 1'b0, '0});
    directed.push_back('{16'd10240, 16'd7680, 1'b0, '0});
    directed.push_back('{16'h5555, 16'hAAAA, 1'b0, '0});
    directed.push_back('{16'hAAAA, 16'h5555, 1'b0, '0});
    foreach (directed[i]) begin
      send_keypoint(directed[i].px, directed[i].py, 1'b0);
      if (directed[i].known) begin
        got = pending_points.pop_back();
        if (got !== directed[i].want) begin
          $error("Directed row %0d: model projection disagrees with table", i);
          errors++;
        end
        pending_points.push_back(directed[i].want);
      end
    end
    drain_pipeline();

    for (int phase = 1; phase <= 13; phase++) begin
      v[REG_CAMERA_Z] = 64'($urandom_range(1) ? $urandom_range(32'h0008_0000)
                                              : $urandom());
      v[REG_NEAR_DISTANCE] = 64'($urandom_range(1, 32'h0010_0000));
      v[REG_TAN_HALF_FOV] = 64'($urandom_range(1) ? $urandom_range(4096, 200000)
                                                  : $urandom_range(24'hFFFFFF));
      v[REG_IMAGE_WIDTH] = 64'($urandom_range(1, 4095));
      v[REG_IMAGE_HEIGHT] = 64'($urandom_range(1, 4095));
      v[REG_FLOOR_HEIGHT] = 64'($urandom());
      v[REG_GRAVITY] = {16'h0, 16'($urandom()), 16'($urandom()), 16'($urandom())};
      case (phase)
        1: begin
          v[REG_CAMERA_Z] = 64'h7FFF_FFFF;
          v[REG_NEAR_DISTANCE] = 64'h7FFF_FFFF;
          v[REG_TAN_HALF_FOV] = 64'hFF_FFFF;
          v[REG_IMAGE_WIDTH] = 64'd4095;
          v[REG_IMAGE_HEIGHT] = 64'd4095;
          v[REG_FLOOR_HEIGHT] = 64'h7FFF_FFFF;
          v[REG_GRAVITY] = 64'h8000_8000_8000;
        end
        2: begin
          v[REG_CAMERA_Z] = 64'h8000_0000;
          v[REG_NEAR_DISTANCE] = 64'd1;
          v[REG_TAN_HALF_FOV] = 64'd0;
          v[REG_IMAGE_WIDTH] = 64'd1;
          v[REG_IMAGE_HEIGHT] = 64'd1;
          v[REG_FLOOR_HEIGHT] = 64'h8000_0000;
          v[REG_GRAVITY] = 64'h7FFF_7FFF_7FFF;
        end
        3: v[REG_NEAR_DISTANCE] = 64'd0;
        4: v[REG_GRAVITY] = 64'd0;
        5: v[REG_FLOOR_HEIGHT] = 64'd0;
        6: v[REG_GRAVITY] = 64'h4000_0000_0000;
        default: ;
      endcase
      for (int r = 0; r < 7; r++) write_register(3'(r), v[r]);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(9) < 7) begin
          px = 16'($urandom_range(32'(16 * img_w)));
          py = 16'($urandom_range(32'(16 * img_h)));
        end else begin
          px = 16'($urandom());
          py = 16'($urandom());
        end
        send_keypoint(px, py, phase != 7);
      end
      drain_pipeline();
    end

    $display("Covered %0d keypoints over 14 camera settings; %0d outputs checked, %0d parallel.",
             points_sent, points_checked, parallel_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
